[hw/rtl/fccg_pkg.sv]
// ----------------------------------------------------------------------------
// Four-corner colour gradient package
// Widths, register indexes and the square-root digit step shared by the block.
// ----------------------------------------------------------------------------
package fccg_pkg;

  localparam int COORD_BITS     = 16;
  localparam int DIST_FRAC_BITS = 8;

  localparam int SQ_W    = 2 * COORD_BITS + 2;
  localparam int ROOT_W  = COORD_BITS + 1 + DIST_FRAC_BITS;
  localparam int REM_W   = ROOT_W + 3;
  localparam int TOT_W   = ROOT_W + 2;
  localparam int PROD_W  = ROOT_W + 8;
  localparam int NUM_W   = ROOT_W + 10;
  localparam int Q_W     = 8;
  localparam int REG_W   = 56;
  localparam int NCORNER = 4;

  typedef enum logic [1:0] {
    REG_LEFT_TOP     = 2'd0,
    REG_LEFT_BOTTOM  = 2'd1,
    REG_RIGHT_TOP    = 2'd2,
    REG_RIGHT_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // One digit of the restoring square root.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [1:0] bits);
    sqrt_st_t         res;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {cur.rem[REM_W-3:0], bits};
    trial  = REM_W'({cur.root, 2'b01});
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

[hw/rtl/four_corner_colour_gradient_top.sv]
// ----------------------------------------------------------------------------
// Four-corner colour gradient
// Distance-weighted RGB interpolation between four configured corner points.
// ----------------------------------------------------------------------------
// Pipeline, from an accepted request to its out_valid strobe: abs difference,
// square, 25 square-root digit stages, two weighting stages and eight
// quotient-bit stages.
// Throughput: one request per clock; busy is never raised and the receiver
// cannot stall. Synchronous active-low reset clears the corner registers
// and every pipeline valid bit.
module four_corner_colour_gradient_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pixel_x,
  input  logic [15:0] in_pixel_y,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_degenerate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [55:0] cfg_data
);

  localparam int CB    = fccg_pkg::COORD_BITS;
  localparam int NSQ   = fccg_pkg::ROOT_W;
  localparam int NDIV  = fccg_pkg::Q_W;
  localparam int LAT   = NSQ + NDIV + 4;

  // Corner registers. They are only written while the pipeline is empty, so
  // every stage may read them directly.
  logic [fccg_pkg::REG_W-1:0] corner_r [0:fccg_pkg::NCORNER-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fccg_pkg::NCORNER; i++) corner_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      corner_r[cfg_index] <= cfg_data;
    end
  end

  assign busy      = 1'b0;

  logic in_acc;
  assign in_acc = start && !busy;

  // Stage 1: absolute coordinate differences per corner.
  logic          v1_r;
  logic [CB-1:0] dx_r [0:3];
  logic [CB-1:0] dy_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      cx = corner_r[i][CB-1:0];
      cy = corner_r[i][16+CB-1:16];
      px = in_pixel_x[CB-1:0];
      py = in_pixel_y[CB-1:0];
      dx_r[i] <= (px >= cx) ? px - cx : cx - px;
      dy_r[i] <= (py >= cy) ? py - cy : cy - py;
    end
  end

  // Stage 2: squared distance, which seeds the square-root digit pipeline.
  logic                      sv_r   [0:NSQ];
  logic [fccg_pkg::SQ_W-1:0] s_r    [0:NSQ][0:3];
  fccg_pkg::sqrt_st_t        sq_r   [0:NSQ][0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else        sv_r[0] <= v1_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      logic [2*CB-1:0] px2;
      logic [2*CB-1:0] py2;
      px2 = dx_r[i] * dx_r[i];
      py2 = dy_r[i] * dy_r[i];
      s_r[0][i]  <= fccg_pkg::SQ_W'(px2) + fccg_pkg::SQ_W'(py2);
      sq_r[0][i] <= '0;
    end
  end

  // Square-root stages: one result bit per stage. The radicand shifts up two
  // bits each stage, so the fraction digits see zero pairs.
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j+1] <= 1'b0;
      else        sv_r[j+1] <= sv_r[j];
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[j+1][i] <= fccg_pkg::sqrt_step(sq_r[j][i],
                          s_r[j][i][fccg_pkg::SQ_W-1:fccg_pkg::SQ_W-2]);
        s_r[j+1][i]  <= {s_r[j][i][fccg_pkg::SQ_W-3:0], 2'b00};
      end
    end
  end

  // Weighting stage A: each corner's colour times its diagonal opposite's
  // distance, and the distance total.
  logic                        mv_r;
  logic [fccg_pkg::PROD_W-1:0] prod_r [0:2][0:3];
  logic [fccg_pkg::TOT_W-1:0]  tot_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else        mv_r <= sv_r[NSQ];
  end

  always_ff @(posedge clk) begin
    logic [fccg_pkg::ROOT_W-1:0] w [0:3];
    w[0] = sq_r[NSQ][3].root;
    w[3] = sq_r[NSQ][0].root;
    w[1] = sq_r[NSQ][2].root;
    w[2] = sq_r[NSQ][1].root;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[ch][i] <= corner_r[i][32+8*ch +: 8] * w[i];
      end
    end
    tot_a_r <= fccg_pkg::TOT_W'(sq_r[NSQ][0].root) + fccg_pkg::TOT_W'(sq_r[NSQ][1].root)
             + fccg_pkg::TOT_W'(sq_r[NSQ][2].root) + fccg_pkg::TOT_W'(sq_r[NSQ][3].root);
  end

  // Weighting stage B: channel numerators, which seed the divider.
  logic                       dv_r  [0:NDIV];
  logic [fccg_pkg::NUM_W-1:0] drem_r[0:NDIV][0:2];
  logic [NDIV-1:0]            q_r   [0:NDIV][0:2];
  logic [fccg_pkg::TOT_W-1:0] dtot_r[0:NDIV];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= mv_r;
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      drem_r[0][ch] <= fccg_pkg::NUM_W'(prod_r[ch][0]) + fccg_pkg::NUM_W'(prod_r[ch][1])
                     + fccg_pkg::NUM_W'(prod_r[ch][2]) + fccg_pkg::NUM_W'(prod_r[ch][3]);
      q_r[0][ch]    <= '0;
    end
    dtot_r[0] <= tot_a_r;
  end

  // Restoring division, one quotient bit per stage, most significant first.
  // The quotient is a weighted mean of 8-bit values and fits in eight bits.
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
    end
    always_ff @(posedge clk) begin
      logic [fccg_pkg::NUM_W-1:0] cmp;
      cmp = fccg_pkg::NUM_W'(dtot_r[k]) << (NDIV - 1 - k);
      for (int ch = 0; ch < 3; ch++) begin
        if (drem_r[k][ch] >= cmp) begin
          drem_r[k+1][ch] <= drem_r[k][ch] - cmp;
          q_r[k+1][ch]    <= {q_r[k][ch][NDIV-2:0], 1'b1};
        end else begin
          drem_r[k+1][ch] <= drem_r[k][ch];
          q_r[k+1][ch]    <= {q_r[k][ch][NDIV-2:0], 1'b0};
        end
      end
      dtot_r[k+1] <= dtot_r[k];
    end
  end

  // The corner registers are read at the first stage (positions) and again at
  // the weighting stage (colours). A write is therefore only taken when no
  // request is in flight and none is being offered in the same cycle, so that
  // every request sees one consistent set of corners.
  logic pipe_busy;

  always_comb begin
    pipe_busy = v1_r || mv_r;
    for (int j = 0; j <= NSQ; j++) pipe_busy = pipe_busy || sv_r[j];
    for (int k = 0; k <= NDIV; k++) pipe_busy = pipe_busy || dv_r[k];
  end

  assign cfg_ready = !start && !pipe_busy;

  // A zero total means the pixel sits on all four corners: colour is forced
  // to black and the degenerate flag is raised.
  logic deg;
  assign deg            = (dtot_r[NDIV] == '0);
  assign out_valid      = dv_r[NDIV];
  assign out_degenerate = deg;
  assign out_red        = deg ? 8'd0 : q_r[NDIV][0];
  assign out_green      = deg ? 8'd0 : q_r[NDIV][1];
  assign out_blue       = deg ? 8'd0 : q_r[NDIV][2];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, LAT) |-> (out_valid == $past(in_acc, LAT)))
    else $error("result strobe does not follow the request latency");

  a_degenerate_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("degenerate result carries colour");

  a_sqrt_to_weight: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (mv_r == $past(sv_r[NSQ])))
    else $error("valid bit lost between root and weighting stages");

endmodule
